// ----- rtl/core/nusc_pkg.sv -----
// Shared types and constants for the start code parser.
package nusc_pkg;

  localparam int OFFSET_BITS_DEF = 32;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONE   = 8'h01;
  localparam logic [7:0] TYPE_MASK  = 8'h1F;
  localparam logic [4:0] TYPE_PREFIX = 5'd14;
  localparam logic [4:0] TYPE_SVC    = 5'd20;

  // Scanner phases: zero bytes seen, armed for 01, type byte, extension bytes.
  localparam logic [2:0] PH_ZERO0 = 3'd0;
  localparam logic [2:0] PH_ZERO1 = 3'd1;
  localparam logic [2:0] PH_ZERO2 = 3'd2;
  localparam logic [2:0] PH_ARMED = 3'd3;
  localparam logic [2:0] PH_TYPE  = 3'd4;
  localparam logic [2:0] PH_EXT1  = 3'd5;
  localparam logic [2:0] PH_EXT2  = 3'd6;
  localparam logic [2:0] PH_EXT3  = 3'd7;

  // One unit record as it leaves the block.
  typedef struct packed {
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
    logic [4:0]  unit_type;
    logic [1:0]  ext_bytes;
    logic        idr_bit;
    logic [2:0]  dep_id;
    logic [3:0]  qual_id;
    logic [2:0]  temp_id;
    logic        is_final;
  } rec_t;

endpackage

// ----- rtl/core/nal_unit_start_code_parser.sv -----
// Start code parser: byte scanner, open unit header fields and record output buffer.
// A record enters the output buffer when the word that closes its unit is accepted.
// Throughput: one input word per cycle unless in_stall; the work is byte compares and adds.
// A two-entry output buffer lets input continue while one record waits to be taken.
// Reset (rst, synchronous, active high) clears the scanner, counters and the output buffer.
// An end-of-stream word also returns the scanner to its reset state.
module nal_unit_start_code_parser #(
  parameter int OFFSET_BITS = nusc_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] unit_offset,
  output logic [31:0] unit_length,
  output logic [4:0]  unit_type,
  output logic [1:0]  ext_bytes,
  output logic        idr_bit,
  output logic [2:0]  dep_id,
  output logic [3:0]  qual_id,
  output logic [2:0]  temp_id,
  output logic        is_final
);
  import nusc_pkg::*;

  localparam logic [OFFSET_BITS-1:0] CNT_ONE  = OFFSET_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] CNT_FOUR = OFFSET_BITS'(4);

  logic [2:0]             match_phase, match_phase_next;
  logic [OFFSET_BITS-1:0] byte_count, byte_count_next;
  logic [OFFSET_BITS-1:0] open_start, open_start_next;
  logic                   seen_first, seen_first_next;
  logic [4:0]             open_type, open_type_next;
  logic [1:0]             open_ext_count, open_ext_count_next;
  logic                   open_idr, open_idr_next;
  logic [2:0]             open_dep, open_dep_next;
  logic [3:0]             open_qual, open_qual_next;
  logic [2:0]             open_temp, open_temp_next;

  logic                   accept;
  logic                   push;
  logic                   pop;
  logic [OFFSET_BITS-1:0] count_inc;
  logic [OFFSET_BITS-1:0] sc_offset;
  logic [OFFSET_BITS-1:0] rec_len;
  logic                   rec_final;
  logic [4:0]             hdr_type;
  rec_t                   rec_new;

  rec_t                   out_rec;
  rec_t                   skid_rec;
  logic                   skid_valid;

  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = skid_valid;
  assign count_inc = byte_count + CNT_ONE;
  assign sc_offset = count_inc - CNT_FOUR;
  assign hdr_type  = 5'(data_byte & TYPE_MASK);

  always_comb begin
    match_phase_next    = match_phase;
    byte_count_next     = byte_count;
    open_start_next     = open_start;
    seen_first_next     = seen_first;
    open_type_next      = open_type;
    open_ext_count_next = open_ext_count;
    open_idr_next       = open_idr;
    open_dep_next       = open_dep;
    open_qual_next      = open_qual;
    open_temp_next      = open_temp;
    push                = 1'b0;
    rec_len             = byte_count - open_start;
    rec_final           = 1'b1;

    if (end_flag) begin
      push                = seen_first;
      match_phase_next    = PH_ZERO0;
      byte_count_next     = '0;
      open_start_next     = '0;
      seen_first_next     = 1'b0;
      open_type_next      = '0;
      open_ext_count_next = '0;
      open_idr_next       = 1'b0;
      open_dep_next       = '0;
      open_qual_next      = '0;
      open_temp_next      = '0;
    end else begin
      byte_count_next = count_inc;
      unique case (match_phase)
        PH_ZERO0, PH_ZERO1, PH_ZERO2: begin
          match_phase_next = (data_byte == BYTE_ZERO) ? match_phase + 3'd1 : PH_ZERO0;
        end
        PH_ARMED: begin
          if (data_byte == BYTE_ONE) begin
            push                = seen_first;
            rec_len             = sc_offset - open_start;
            rec_final           = 1'b0;
            seen_first_next     = 1'b1;
            open_start_next     = sc_offset;
            open_type_next      = '0;
            open_ext_count_next = '0;
            open_idr_next       = 1'b0;
            open_dep_next       = '0;
            open_qual_next      = '0;
            open_temp_next      = '0;
            match_phase_next    = PH_TYPE;
          end else if (data_byte != BYTE_ZERO) begin
            match_phase_next = PH_ZERO0;
          end
        end
        PH_TYPE: begin
          open_type_next   = hdr_type;
          match_phase_next = (hdr_type == TYPE_SVC || hdr_type == TYPE_PREFIX) ?
                             PH_EXT1 : PH_ZERO0;
        end
        PH_EXT1: begin
          open_idr_next       = data_byte[6];
          open_ext_count_next = 2'd1;
          match_phase_next    = PH_EXT2;
        end
        PH_EXT2: begin
          open_dep_next       = data_byte[6:4];
          open_qual_next      = data_byte[3:0];
          open_ext_count_next = 2'd2;
          match_phase_next    = PH_EXT3;
        end
        PH_EXT3: begin
          open_temp_next      = data_byte[7:5];
          open_ext_count_next = 2'd3;
          match_phase_next    = PH_ZERO0;
        end
        default: begin
          match_phase_next = PH_ZERO0;
        end
      endcase
    end
  end

  always_comb begin
    rec_new.unit_offset = 32'(open_start);
    rec_new.unit_length = 32'(rec_len);
    rec_new.unit_type   = open_type;
    rec_new.ext_bytes   = open_ext_count;
    rec_new.idr_bit     = open_idr;
    rec_new.dep_id      = open_dep;
    rec_new.qual_id     = open_qual;
    rec_new.temp_id     = open_temp;
    rec_new.is_final    = rec_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_phase    <= PH_ZERO0;
      byte_count     <= '0;
      open_start     <= '0;
      seen_first     <= 1'b0;
      open_type      <= '0;
      open_ext_count <= '0;
      open_idr       <= 1'b0;
      open_dep       <= '0;
      open_qual      <= '0;
      open_temp      <= '0;
    end else if (accept) begin
      match_phase    <= match_phase_next;
      byte_count     <= byte_count_next;
      open_start     <= open_start_next;
      seen_first     <= seen_first_next;
      open_type      <= open_type_next;
      open_ext_count <= open_ext_count_next;
      open_idr       <= open_idr_next;
      open_dep       <= open_dep_next;
      open_qual      <= open_qual_next;
      open_temp      <= open_temp_next;
    end
  end

  // The skid entry only fills while the output register holds a stalled record;
  // input stalls while it is full, so no record can arrive then.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && push;
      end
    end else if (accept && push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_rec <= skid_valid ? skid_rec : rec_new;
    end else if (accept && push) begin
      skid_rec <= rec_new;
    end
  end

  assign unit_offset = out_rec.unit_offset;
  assign unit_length = out_rec.unit_length;
  assign unit_type   = out_rec.unit_type;
  assign ext_bytes   = out_rec.ext_bytes;
  assign idr_bit     = out_rec.idr_bit;
  assign dep_id      = out_rec.dep_id;
  assign qual_id     = out_rec.qual_id;
  assign temp_id     = out_rec.temp_id;
  assign is_final    = out_rec.is_final;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a record while the output register is empty");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_flag |=> !seen_first && byte_count == '0)
    else $error("end of stream did not return the scanner to its reset state");

  a_start_code_opens: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !end_flag && match_phase == PH_ARMED && data_byte == BYTE_ONE
    |=> seen_first && match_phase == PH_TYPE)
    else $error("start code did not open a unit");
`endif

endmodule
